### sv/lfo_ws_pkg.sv
// Package for the LFO waveform shaper: wave and register codes, fixed
// widths and the constants used to build the quarter-wave sine table.
// No dependencies.
package lfo_ws_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 2;

  typedef enum logic [2:0] {
    WAVE_COSINE   = 3'd0,
    WAVE_TRIANGLE = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_RAMP_UP  = 3'd3,
    WAVE_RAMP_DN  = 3'd4,
    WAVE_RANDOM   = 3'd5
  } wave_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WAVE_SELECT = 2'd0,
    CFG_AMP_GAIN    = 2'd1,
    CFG_LVL_OFFSET  = 2'd2
  } cfg_reg_t;

  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [15:0] HALF_SCALE = 16'h8000;

  // (2k+2)(2k+3) for the Taylor terms of sin
  localparam logic [63:0] TAYLOR_DIV [9] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
  };

endpackage

### sv/lfo_ws_sine_rom.sv
// Quarter-wave sine table, Q1.15 (0..32768), ENTRIES+1 entries built at
// elaboration from a fixed-point Taylor series. Depends on lfo_ws_pkg.
module lfo_ws_sine_rom #(
  parameter int ENTRIES = 256
) (
  input  logic [$clog2(ENTRIES+1)-1:0] addr,
  output logic [15:0]                  data
);
  import lfo_ws_pkg::*;

  function automatic logic [15:0] quarter_sine(input int i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] sum;
    logic [63:0] q;
    x = (HALF_PI_Q30 * 64'(i)) / ENTRIES;
    x2 = (x * x) >> 30;
    term = x;
    pos = '0;
    neg = '0;
    for (int k = 0; k < 9; k++) begin
      if (k % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
    end
    sum = (pos > neg) ? pos - neg : 64'd0;
    q = (sum + 64'd16384) >> 15;
    if (q > 64'd32768) begin
      q = 64'd32768;
    end
    return q[15:0];
  endfunction

  logic [15:0] rom [ENTRIES+1];

  for (genvar g = 0; g <= ENTRIES; g++) begin : g_rom
    assign rom[g] = quarter_sine(g);
  end

  assign data = rom[addr];

endmodule

### sv/lfo_waveform_shaper.sv
// LFO waveform shaper top level: input register, wave shaping, scaling,
// offset and saturation into an output register. Depends on lfo_ws_pkg
// and lfo_ws_sine_rom.
//
// Usage:
//   in_*  : one phase value per transaction, unsigned fraction of the cycle
//           in the low PHASE_BITS bits of in_tdata.
//   out_* : one Q0.16 sample per transaction in out_tdata[15:0].
//   cfg_* : register writes (0 wave select, 1 amplitude gain, 2 offset),
//           taken on any clock with cfg_we high; write only while idle.
// An input transaction reaches out_tvalid through the input register, then
// the result register. Throughput: one transaction per cycle while the
// output is not stalled; the table lookup, one 16x16 multiply and the
// add/saturate sit in one stage.
// Reset (synchronous, rst_n low): both stages empty, registers to their
// defaults (cosine, gain 65535, offset 0), held random 0, LFSR seed 1.
// Stall: a held result keeps out_tdata stable; the input register still
// takes one more transaction, after which in_tready drops until the
// result is taken.
module lfo_waveform_shaper #(
  parameter int SINE_TABLE_ENTRIES = 256,
  parameter int PHASE_BITS         = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((PHASE_BITS+7)/8)*8-1:0]     in_tdata,   // [PHASE_BITS-1:0] phase
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lfo_ws_pkg::SAMPLE_W-1:0]     out_tdata,  // [15:0] sample_out
  input  logic                                cfg_we,
  input  logic [lfo_ws_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lfo_ws_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lfo_ws_pkg::*;

  localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int PROD_W = 14 + IDX_W;

  // configuration
  wave_t       wave_sel_r;
  logic [15:0] amp_gain_r;
  logic [15:0] lvl_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_sel_r   <= WAVE_COSINE;
      amp_gain_r   <= 16'hFFFF;
      lvl_offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_WAVE_SELECT: wave_sel_r   <= wave_t'(cfg_wdata[2:0]);
        CFG_AMP_GAIN:    amp_gain_r   <= cfg_wdata;
        CFG_LVL_OFFSET:  lvl_offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // phase normalization to 16 bits and table index
  logic [15:0]       p_in;
  logic [PROD_W-1:0] idx_prod;
  logic [IDX_W-1:0]  idx_in;

  if (PHASE_BITS >= 16) begin : g_phase_dn
    assign p_in = in_tdata[PHASE_BITS-1 -: 16];
  end else begin : g_phase_up
    assign p_in = {in_tdata[PHASE_BITS-1:0], {(16-PHASE_BITS){1'b0}}};
  end

  assign idx_prod = PROD_W'(p_in[13:0]) * PROD_W'(SINE_TABLE_ENTRIES);
  assign idx_in   = idx_prod[PROD_W-1:14];

  // handshake
  logic s1_v_r;
  logic out_v_r;
  logic s2_free_c;
  logic s1_adv_c;
  logic in_acc_c;

  assign s2_free_c = !out_v_r || out_tready;
  assign s1_adv_c  = s1_v_r && s2_free_c;
  assign in_tready = !s1_v_r || s2_free_c;
  assign in_acc_c  = in_tvalid && in_tready;

  // input register
  logic [15:0]      s1_p_r;
  logic [IDX_W-1:0] s1_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc_c) begin
      s1_p_r   <= p_in;
      s1_idx_r <= idx_in;
    end
  end

  // cosine from the quarter-wave table
  logic [IDX_W-1:0] rom_addr;
  logic [15:0]      rom_data;
  logic [1:0]       quad;
  logic [16:0]      cos_lvl;

  assign quad     = s1_p_r[15:14];
  assign rom_addr = quad[0] ? s1_idx_r : IDX_W'(SINE_TABLE_ENTRIES) - s1_idx_r;

  lfo_ws_sine_rom #(
    .ENTRIES (SINE_TABLE_ENTRIES)
  ) u_sine_rom (
    .addr (rom_addr),
    .data (rom_data)
  );

  assign cos_lvl = (quad == 2'd1 || quad == 2'd2) ? {1'b0, HALF_SCALE} + {1'b0, rom_data}
                                                   : {1'b0, HALF_SCALE} - {1'b0, rom_data};

  // random sample-and-hold
  logic [31:0] noise_lfsr_r;
  logic [31:0] noise_lfsr_nxt;
  logic [15:0] held_random_r;
  logic [15:0] held_random_nxt;
  logic        draw_c;

  assign draw_c = (wave_sel_r == WAVE_RANDOM) && (s1_p_r > HALF_SCALE);

  always_comb begin
    noise_lfsr_nxt  = noise_lfsr_r;
    held_random_nxt = held_random_r;
    if (draw_c) begin
      noise_lfsr_nxt  = noise_lfsr_r[0] ? ({1'b0, noise_lfsr_r[31:1]} ^ LFSR_TAPS)
                                        : {1'b0, noise_lfsr_r[31:1]};
      held_random_nxt = noise_lfsr_nxt[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_lfsr_r  <= LFSR_SEED;
      held_random_r <= '0;
    end else if (s1_adv_c) begin
      noise_lfsr_r  <= noise_lfsr_nxt;
      held_random_r <= held_random_nxt;
    end
  end

  // wave select
  logic [15:0] ramp_up;
  logic [15:0] ramp_dn;
  logic [15:0] wave_c;

  assign ramp_up = {s1_p_r[14:0], 1'b0};
  assign ramp_dn = (ramp_up == '0) ? 16'hFFFF : 16'(~ramp_up + 16'd1);

  always_comb begin
    case (wave_sel_r)
      WAVE_COSINE:   wave_c = cos_lvl[16] ? 16'hFFFF : cos_lvl[15:0];
      WAVE_TRIANGLE: wave_c = s1_p_r[15] ? ramp_dn : ramp_up;
      WAVE_SQUARE:   wave_c = s1_p_r[15] ? 16'hFFFF : 16'h0000;
      WAVE_RAMP_UP:  wave_c = ramp_up;
      WAVE_RAMP_DN:  wave_c = ramp_dn;
      WAVE_RANDOM:   wave_c = held_random_nxt;
      default:       wave_c = '0;
    endcase
  end

  // scale (divide by 65535 with rounding), offset, saturate
  logic [31:0] scaled_c;
  logic [32:0] div_c;
  logic [15:0] quot_c;
  logic [16:0] sum_c;
  logic [15:0] sample_c;

  assign scaled_c = 32'(wave_c) * 32'(amp_gain_r) + 32'd32767;
  assign div_c    = 33'(scaled_c) + 33'(scaled_c[31:16]) + 33'd1;
  assign quot_c   = div_c[31:16];
  assign sum_c    = 17'(quot_c) + 17'(lvl_offset_r);
  assign sample_c = sum_c[16] ? 16'hFFFF : sum_c[15:0];

  // result register
  logic [15:0] out_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_free_c) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv_c) begin
      out_sample_r <= sample_c;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_sample_r;

  // checks
  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    noise_lfsr_r != '0)
    else $error("noise LFSR reached the all-zero lock state");

  a_held_only_on_random: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_adv_c && draw_c) |=> $stable(held_random_r) && $stable(noise_lfsr_r))
    else $error("random state changed without a random draw");

  a_out_from_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s1_v_r))
    else $error("result appeared without an item in the input register");

endmodule
